/* rtl/core/vhep_pkg.sv */
// shared types, constants and the priority table for the veto hit edge priority matcher
package vhep_pkg;

  // event limits
  localparam int MAX_MATCHED = 128;
  localparam int MAX_HITS    = 1024;
  localparam int STATIONS    = 12;

  // field widths
  localparam int STATION_W = 4;
  localparam int CHAN_W    = 17;
  localparam int TIME_W    = 32;
  localparam int EDGE_W    = 4;
  localparam int PRIO_W    = 4;
  localparam int INDEX_W   = 10;
  localparam int MATCH_W   = 8;
  localparam int PAIR_W    = 11;
  localparam int MASK_W    = 12;
  localparam int NOISY_NUM = 5;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TIME     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATION_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISY_A      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISY_B      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISY_C      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISY_D      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISY_E      = 3'd6;

  // constants
  localparam logic [PRIO_W-1:0]        PRIO_SELECT = 4'd9;
  localparam logic [CHAN_W-1:0]        EMPTY_SLOT  = 17'h1FFFF;
  localparam logic signed [TIME_W-1:0] DIFF_NONE   = -32'sd25599744;
  localparam logic [TIME_W-1:0]        DIFF_NONE_MAG = 32'd25599744;
  localparam logic [TIME_W-1:0]        DIFF_POS_SAT  = 32'h7FFF_FFFF;
  localparam logic [TIME_W-1:0]        DIFF_NEG_SAT  = 32'h8000_0000;

  localparam logic [MATCH_W-1:0] MATCH_CAP = MATCH_W'(MAX_MATCHED);
  localparam logic [PAIR_W-1:0]  PAIR_CAP  = PAIR_W'(MAX_HITS);
  localparam logic [STATION_W:0] STATION_LAST = (STATION_W+1)'(STATIONS);

  // noisy channel reset values
  localparam logic [CHAN_W-1:0] NOISY_A_RST = 17'd84083;
  localparam logic [CHAN_W-1:0] NOISY_B_RST = 17'd90083;
  localparam logic [CHAN_W-1:0] NOISY_C_RST = 17'd103040;
  localparam logic [CHAN_W-1:0] NOISY_D_RST = 17'd121101;
  localparam logic [CHAN_W-1:0] NOISY_E_RST = 17'd123083;

  // configuration register set
  typedef struct packed {
    logic signed [TIME_W-1:0]            ref_time;
    logic [MASK_W-1:0]                   station_mask;
    logic [NOISY_NUM-1:0][CHAN_W-1:0]    noisy;
  } cfg_t;

  // classified hit held in the input register
  typedef struct packed {
    logic                     kept;
    logic [PRIO_W-1:0]        prio;
    logic                     low_pair;
    logic                     high_pair;
    logic                     select;
    logic signed [TIME_W-1:0] dt;
    logic [TIME_W-1:0]        dt_mag;
    logic                     last;
  } hit_info_t;

  // result word
  typedef struct packed {
    logic [INDEX_W-1:0]       hit_index;
    logic                     hit_kept;
    logic [PRIO_W-1:0]        hit_priority;
    logic                     hit_matched;
    logic                     event_done;
    logic                     event_matched;
    logic [MATCH_W-1:0]       matched_count;
    logic [PAIR_W-1:0]        low_pair_count;
    logic [PAIR_W-1:0]        high_pair_count;
    logic [PRIO_W-1:0]        best_priority;
    logic signed [TIME_W-1:0] best_time_diff;
  } result_t;

  // edge mask to priority
  function automatic logic [PRIO_W-1:0] prio_lookup(input logic [EDGE_W-1:0] edges);
    logic [PRIO_W-1:0] p;
    case (edges)
      4'd0:    p = 4'd0;
      4'd1:    p = 4'd4;
      4'd2:    p = 4'd5;
      4'd3:    p = 4'd10;
      4'd4:    p = 4'd2;
      4'd5:    p = 4'd7;
      4'd6:    p = 4'd11;
      4'd7:    p = 4'd13;
      4'd8:    p = 4'd1;
      4'd9:    p = 4'd12;
      4'd10:   p = 4'd6;
      4'd11:   p = 4'd14;
      4'd12:   p = 4'd3;
      4'd13:   p = 4'd8;
      4'd14:   p = 4'd9;
      default: p = 4'd15;
    endcase
    return p;
  endfunction

endpackage

/* rtl/core/vhep_cfg_regs.sv */
// configuration registers: reference time, station mask and noisy channel slots
module vhep_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vhep_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vhep_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output vhep_pkg::cfg_t                    cfg
);

  vhep_pkg::cfg_t cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_time     <= '0;
      cfg_r.station_mask <= '0;
      cfg_r.noisy[0]     <= vhep_pkg::NOISY_A_RST;
      cfg_r.noisy[1]     <= vhep_pkg::NOISY_B_RST;
      cfg_r.noisy[2]     <= vhep_pkg::NOISY_C_RST;
      cfg_r.noisy[3]     <= vhep_pkg::NOISY_D_RST;
      cfg_r.noisy[4]     <= vhep_pkg::NOISY_E_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vhep_pkg::CFG_REF_TIME: begin
          cfg_r.ref_time <= cfg_wdata[vhep_pkg::TIME_W-1:0];
        end
        vhep_pkg::CFG_STATION_MASK: begin
          cfg_r.station_mask <= cfg_wdata[vhep_pkg::MASK_W-1:0];
        end
        vhep_pkg::CFG_NOISY_A: begin
          cfg_r.noisy[0] <= cfg_wdata[vhep_pkg::CHAN_W-1:0];
        end
        vhep_pkg::CFG_NOISY_B: begin
          cfg_r.noisy[1] <= cfg_wdata[vhep_pkg::CHAN_W-1:0];
        end
        vhep_pkg::CFG_NOISY_C: begin
          cfg_r.noisy[2] <= cfg_wdata[vhep_pkg::CHAN_W-1:0];
        end
        vhep_pkg::CFG_NOISY_D: begin
          cfg_r.noisy[3] <= cfg_wdata[vhep_pkg::CHAN_W-1:0];
        end
        vhep_pkg::CFG_NOISY_E: begin
          cfg_r.noisy[4] <= cfg_wdata[vhep_pkg::CHAN_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/vhep_hit_stage.sv */
// input register: filters the hit, looks up its priority and forms the saturated time difference
module vhep_hit_stage (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vhep_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [vhep_pkg::STATION_W-1:0]       in_station,
  input  logic [vhep_pkg::CHAN_W-1:0]          in_channel_id,
  input  logic signed [vhep_pkg::TIME_W-1:0]   in_hit_time,
  input  logic [vhep_pkg::EDGE_W-1:0]          in_edge_mask,
  input  logic                                 in_last_hit,
  output logic                                 s1_valid,
  output vhep_pkg::hit_info_t                  s1_info,
  input  logic                                 s1_take
);

  logic                              valid_r;
  vhep_pkg::hit_info_t               info_r;
  vhep_pkg::hit_info_t               info_nxt;
  logic                              station_ok;
  logic [vhep_pkg::STATION_W-1:0]    mask_idx;
  logic [15:0]                       mask_ext;
  logic                              noisy_hit;
  logic [vhep_pkg::TIME_W:0]         diff_wide;
  logic [vhep_pkg::TIME_W-1:0]       dt_sat;
  logic [vhep_pkg::PRIO_W-1:0]       prio;

  // station range and mask
  assign station_ok = (in_station != '0) &&
                      ({1'b0, in_station} <= vhep_pkg::STATION_LAST);
  assign mask_idx   = in_station - 4'd1;
  assign mask_ext   = 16'(cfg.station_mask);

  // noisy channel compare over the five slots
  always_comb begin
    noisy_hit = 1'b0;
    for (int i = 0; i < vhep_pkg::NOISY_NUM; i++) begin
      if (cfg.noisy[i] != vhep_pkg::EMPTY_SLOT && cfg.noisy[i] == in_channel_id) begin
        noisy_hit = 1'b1;
      end
    end
  end

  // saturated difference to the reference time
  assign diff_wide = {in_hit_time[vhep_pkg::TIME_W-1], in_hit_time} -
                     {cfg.ref_time[vhep_pkg::TIME_W-1], cfg.ref_time};

  always_comb begin
    if (diff_wide[vhep_pkg::TIME_W] != diff_wide[vhep_pkg::TIME_W-1]) begin
      dt_sat = diff_wide[vhep_pkg::TIME_W] ? vhep_pkg::DIFF_NEG_SAT : vhep_pkg::DIFF_POS_SAT;
    end else begin
      dt_sat = diff_wide[vhep_pkg::TIME_W-1:0];
    end
  end

  assign prio = vhep_pkg::prio_lookup(in_edge_mask);

  // classified word
  always_comb begin
    info_nxt.kept      = station_ok && !mask_ext[mask_idx] && !noisy_hit;
    info_nxt.prio      = prio;
    info_nxt.low_pair  = in_edge_mask[0] && in_edge_mask[3];
    info_nxt.high_pair = in_edge_mask[1] && in_edge_mask[2];
    info_nxt.select    = prio >= vhep_pkg::PRIO_SELECT;
    info_nxt.dt        = dt_sat;
    info_nxt.dt_mag    = dt_sat[vhep_pkg::TIME_W-1] ? (~dt_sat + 32'd1) : dt_sat;
    info_nxt.last      = in_last_hit;
  end

  assign in_ready = !valid_r || s1_take;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      info_r <= info_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_info  = info_r;

endmodule

/* rtl/core/vhep_event_acc.sv */
// event totals and result register
module vhep_event_acc (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s1_valid,
  input  vhep_pkg::hit_info_t    s1_info,
  output logic                   s1_take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vhep_pkg::result_t      res
);

  logic [vhep_pkg::INDEX_W-1:0]       hit_cnt_r;
  logic [vhep_pkg::MATCH_W-1:0]       matched_total_r;
  logic [vhep_pkg::PAIR_W-1:0]        low_pairs_r;
  logic [vhep_pkg::PAIR_W-1:0]        high_pairs_r;
  logic [vhep_pkg::PRIO_W-1:0]        top_prio_r;
  logic signed [vhep_pkg::TIME_W-1:0] closest_r;
  logic [vhep_pkg::TIME_W-1:0]        closest_mag_r;

  logic [vhep_pkg::MATCH_W-1:0]       matched_total_nxt;
  logic [vhep_pkg::PAIR_W-1:0]        low_pairs_nxt;
  logic [vhep_pkg::PAIR_W-1:0]        high_pairs_nxt;
  logic [vhep_pkg::PRIO_W-1:0]        top_prio_nxt;
  logic signed [vhep_pkg::TIME_W-1:0] closest_nxt;
  logic [vhep_pkg::TIME_W-1:0]        closest_mag_nxt;
  logic                               matched;

  logic                               out_valid_r;
  vhep_pkg::result_t                  res_r;
  vhep_pkg::result_t                  res_nxt;

  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  // running totals with this hit folded in
  always_comb begin
    matched_total_nxt = matched_total_r;
    low_pairs_nxt     = low_pairs_r;
    high_pairs_nxt    = high_pairs_r;
    top_prio_nxt      = top_prio_r;
    closest_nxt       = closest_r;
    closest_mag_nxt   = closest_mag_r;
    matched           = 1'b0;
    if (s1_info.kept) begin
      if (s1_info.low_pair && low_pairs_r < vhep_pkg::PAIR_CAP) begin
        low_pairs_nxt = low_pairs_r + 11'd1;
      end
      if (s1_info.high_pair && high_pairs_r < vhep_pkg::PAIR_CAP) begin
        high_pairs_nxt = high_pairs_r + 11'd1;
      end
      if (s1_info.prio > top_prio_r) begin
        top_prio_nxt = s1_info.prio;
      end
      if (s1_info.select) begin
        // ties keep the earlier difference
        if (s1_info.dt_mag < closest_mag_r) begin
          closest_nxt     = s1_info.dt;
          closest_mag_nxt = s1_info.dt_mag;
        end
        if (matched_total_r < vhep_pkg::MATCH_CAP) begin
          matched_total_nxt = matched_total_r + 8'd1;
          matched           = 1'b1;
        end
      end
    end
  end

  // result word; totals only on the last hit
  always_comb begin
    res_nxt                 = '0;
    res_nxt.hit_index       = hit_cnt_r;
    res_nxt.hit_kept        = s1_info.kept;
    res_nxt.hit_priority    = s1_info.prio;
    res_nxt.hit_matched     = matched;
    res_nxt.event_done      = s1_info.last;
    if (s1_info.last) begin
      res_nxt.event_matched   = top_prio_nxt >= vhep_pkg::PRIO_SELECT;
      res_nxt.matched_count   = matched_total_nxt;
      res_nxt.low_pair_count  = low_pairs_nxt;
      res_nxt.high_pair_count = high_pairs_nxt;
      res_nxt.best_priority   = top_prio_nxt;
      res_nxt.best_time_diff  = closest_nxt;
    end
  end

  // event state, cleared after the last hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r       <= '0;
      matched_total_r <= '0;
      low_pairs_r     <= '0;
      high_pairs_r    <= '0;
      top_prio_r      <= '0;
      closest_r       <= vhep_pkg::DIFF_NONE;
      closest_mag_r   <= vhep_pkg::DIFF_NONE_MAG;
    end else if (s1_take) begin
      if (s1_info.last) begin
        hit_cnt_r       <= '0;
        matched_total_r <= '0;
        low_pairs_r     <= '0;
        high_pairs_r    <= '0;
        top_prio_r      <= '0;
        closest_r       <= vhep_pkg::DIFF_NONE;
        closest_mag_r   <= vhep_pkg::DIFF_NONE_MAG;
      end else begin
        hit_cnt_r       <= hit_cnt_r + 10'd1;
        matched_total_r <= matched_total_nxt;
        low_pairs_r     <= low_pairs_nxt;
        high_pairs_r    <= high_pairs_nxt;
        top_prio_r      <= top_prio_nxt;
        closest_r       <= closest_nxt;
        closest_mag_r   <= closest_mag_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

`ifndef SYNTHESIS
  // match count never passes the cap
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> matched_total_r <= vhep_pkg::MATCH_CAP)
    else $error("match count above cap");

  // last hit returns the event state to its cleared value
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && s1_info.last |=> hit_cnt_r == '0 && matched_total_r == '0 &&
      closest_r == vhep_pkg::DIFF_NONE)
    else $error("event state not cleared after last hit");

  // totals read zero before the last hit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.event_done |-> res_r.matched_count == '0 &&
      res_r.best_priority == '0 && res_r.best_time_diff == '0)
    else $error("totals shown before last hit");

  // a matched hit is kept and of selecting priority
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.hit_matched |-> res_r.hit_kept &&
      res_r.hit_priority >= vhep_pkg::PRIO_SELECT)
    else $error("matched hit not kept or low priority");
`endif

endmodule

/* rtl/core/veto_hit_edge_priority_matcher.sv */
// top level of the veto hit edge priority matcher
//
//   channel  | handshake            | contents
//   ---------+----------------------+-----------------------------------------
//   in_      | in_valid / in_ready  | station, channel id, time, edges, last
//   out_     | out_valid / out_ready| hit index, flags, event totals
//   cfg_     | cfg_we               | register index and write data
//
// one word per cycle sustained while the output is not stalled; a word passes
// the input register with filter, lookup and difference, then the event
// totals and result register.
// reset is synchronous, active low; it clears the event state and loads the
// register defaults. a stalled output holds the result and the input register,
// while one more word can still wait in the input register.
module veto_hit_edge_priority_matcher (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [vhep_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vhep_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // hit input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [vhep_pkg::STATION_W-1:0]       in_station,
  input  logic [vhep_pkg::CHAN_W-1:0]          in_channel_id,
  input  logic signed [vhep_pkg::TIME_W-1:0]   in_hit_time,
  input  logic [vhep_pkg::EDGE_W-1:0]          in_edge_mask,
  input  logic                                 in_last_hit,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [vhep_pkg::INDEX_W-1:0]         out_hit_index,
  output logic                                 out_hit_kept,
  output logic [vhep_pkg::PRIO_W-1:0]          out_hit_priority,
  output logic                                 out_hit_matched,
  output logic                                 out_event_done,
  output logic                                 out_event_matched,
  output logic [vhep_pkg::MATCH_W-1:0]         out_matched_count,
  output logic [vhep_pkg::PAIR_W-1:0]          out_low_pair_count,
  output logic [vhep_pkg::PAIR_W-1:0]          out_high_pair_count,
  output logic [vhep_pkg::PRIO_W-1:0]          out_best_priority,
  output logic signed [vhep_pkg::TIME_W-1:0]   out_best_time_diff
);

  vhep_pkg::cfg_t      cfg;
  vhep_pkg::hit_info_t s1_info;
  vhep_pkg::result_t   res;
  logic                s1_valid;
  logic                s1_take;

  // configuration registers
  vhep_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register with hit classification
  vhep_hit_stage u_hit (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_station    (in_station),
    .in_channel_id (in_channel_id),
    .in_hit_time   (in_hit_time),
    .in_edge_mask  (in_edge_mask),
    .in_last_hit   (in_last_hit),
    .s1_valid      (s1_valid),
    .s1_info       (s1_info),
    .s1_take       (s1_take)
  );

  // event totals and result register
  vhep_event_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_info   (s1_info),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // result word to ports
  assign out_hit_index       = res.hit_index;
  assign out_hit_kept        = res.hit_kept;
  assign out_hit_priority    = res.hit_priority;
  assign out_hit_matched     = res.hit_matched;
  assign out_event_done      = res.event_done;
  assign out_event_matched   = res.event_matched;
  assign out_matched_count   = res.matched_count;
  assign out_low_pair_count  = res.low_pair_count;
  assign out_high_pair_count = res.high_pair_count;
  assign out_best_priority   = res.best_priority;
  assign out_best_time_diff  = res.best_time_diff;

endmodule

/* test/tb_veto_hit_edge_priority_matcher.sv */
// testbench for the veto hit edge priority matcher: directed table, random events, word checks
module tb_veto_hit_edge_priority_matcher;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_HITS  = 80;
  localparam int LONG_EVENT   = 1030;
  localparam int LONG_FULL    = 1026;
  localparam int DRAIN_CYCLES = 4;
  localparam longint DT_MAX   = 64'sd2147483647;
  localparam longint DT_MIN   = -64'sd2147483648;
  // nibble n holds the priority of edge mask n
  localparam logic [63:0] EDGE_PRIO = 64'hF983_E6C1_DB72_A540;

  typedef struct packed {
    logic [vhep_pkg::STATION_W-1:0]     station;
    logic [vhep_pkg::CHAN_W-1:0]        channel;
    logic signed [vhep_pkg::TIME_W-1:0] hit_time;
    logic [vhep_pkg::EDGE_W-1:0]        edges;
    logic                               last;
  } hit_t;

  typedef enum logic {ROW_HIT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    hit_t                            hit;
    logic [vhep_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [vhep_pkg::CFG_DATA_W-1:0] reg_val;
    bit                              typed;
    vhep_pkg::result_t               want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [vhep_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vhep_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [vhep_pkg::STATION_W-1:0] in_station;
  logic [vhep_pkg::CHAN_W-1:0] in_channel_id;
  logic signed [vhep_pkg::TIME_W-1:0] in_hit_time;
  logic [vhep_pkg::EDGE_W-1:0] in_edge_mask;
  logic in_last_hit;
  logic out_valid;
  logic out_ready;
  logic [vhep_pkg::INDEX_W-1:0] out_hit_index;
  logic out_hit_kept;
  logic [vhep_pkg::PRIO_W-1:0] out_hit_priority;
  logic out_hit_matched;
  logic out_event_done;
  logic out_event_matched;
  logic [vhep_pkg::MATCH_W-1:0] out_matched_count;
  logic [vhep_pkg::PAIR_W-1:0] out_low_pair_count;
  logic [vhep_pkg::PAIR_W-1:0] out_high_pair_count;
  logic [vhep_pkg::PRIO_W-1:0] out_best_priority;
  logic signed [vhep_pkg::TIME_W-1:0] out_best_time_diff;

  // register mirror
  logic signed [vhep_pkg::TIME_W-1:0] reg_ref;
  logic [vhep_pkg::MASK_W-1:0] reg_mask;
  logic [vhep_pkg::CHAN_W-1:0] reg_noisy [vhep_pkg::NOISY_NUM];

  // running event totals
  logic [vhep_pkg::INDEX_W-1:0] ev_hits;
  logic [vhep_pkg::MATCH_W-1:0] ev_matched;
  logic [vhep_pkg::PAIR_W-1:0] ev_low;
  logic [vhep_pkg::PAIR_W-1:0] ev_high;
  logic [vhep_pkg::PRIO_W-1:0] ev_top;
  logic signed [vhep_pkg::TIME_W-1:0] ev_closest;

  vhep_pkg::result_t pending_words [$];
  plan_row_t plan [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit src_busy = 1'b0;
  bit sink_busy = 1'b0;

  veto_hit_edge_priority_matcher u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_station          (in_station),
    .in_channel_id       (in_channel_id),
    .in_hit_time         (in_hit_time),
    .in_edge_mask        (in_edge_mask),
    .in_last_hit         (in_last_hit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit_index       (out_hit_index),
    .out_hit_kept        (out_hit_kept),
    .out_hit_priority    (out_hit_priority),
    .out_hit_matched     (out_hit_matched),
    .out_event_done      (out_event_done),
    .out_event_matched   (out_event_matched),
    .out_matched_count   (out_matched_count),
    .out_low_pair_count  (out_low_pair_count),
    .out_high_pair_count (out_high_pair_count),
    .out_best_priority   (out_best_priority),
    .out_best_time_diff  (out_best_time_diff)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_busy && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void clear_event();
    ev_hits = '0;
    ev_matched = '0;
    ev_low = '0;
    ev_high = '0;
    ev_top = '0;
    ev_closest = vhep_pkg::DIFF_NONE;
  endfunction

  // filter, tally and build the word for one accepted hit
  function automatic vhep_pkg::result_t tally_hit(hit_t h);
    vhep_pkg::result_t r;
    logic [vhep_pkg::PRIO_W-1:0] prio;
    bit kept;
    bit matched;
    longint dt;
    r = '0;
    prio = EDGE_PRIO[h.edges*4 +: 4];
    kept = (h.station != 0) && (h.station <= vhep_pkg::STATIONS);
    if (kept && reg_mask[4'(h.station - 4'd1)]) kept = 1'b0;
    for (int i = 0; i < vhep_pkg::NOISY_NUM; i++)
      if (reg_noisy[i] != vhep_pkg::EMPTY_SLOT && reg_noisy[i] == h.channel) kept = 1'b0;
    matched = 1'b0;
    if (kept) begin
      if (h.edges[0] && h.edges[3] && ev_low < vhep_pkg::MAX_HITS) ev_low = ev_low + 1'b1;
      if (h.edges[1] && h.edges[2] && ev_high < vhep_pkg::MAX_HITS) ev_high = ev_high + 1'b1;
      if (prio > ev_top) ev_top = prio;
      if (prio >= vhep_pkg::PRIO_SELECT) begin
        dt = longint'(h.hit_time) - longint'(reg_ref);
        if (dt > DT_MAX) dt = DT_MAX;
        if (dt < DT_MIN) dt = DT_MIN;
        if (magnitude(dt) < magnitude(longint'(ev_closest)))
          ev_closest = dt[vhep_pkg::TIME_W-1:0];
        if (ev_matched < vhep_pkg::MAX_MATCHED) begin
          ev_matched = ev_matched + 1'b1;
          matched = 1'b1;
        end
      end
    end
    r.hit_index = ev_hits;
    r.hit_kept = kept;
    r.hit_priority = prio;
    r.hit_matched = matched;
    r.event_done = h.last;
    if (h.last) begin
      r.event_matched = (ev_top >= vhep_pkg::PRIO_SELECT);
      r.matched_count = ev_matched;
      r.low_pair_count = ev_low;
      r.high_pair_count = ev_high;
      r.best_priority = ev_top;
      r.best_time_diff = ev_closest;
      clear_event();
    end else begin
      ev_hits = ev_hits + 1'b1;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    vhep_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: expected none actual hit_index %0d", $time,
                 out_hit_index);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        compare_field("hit_index", want.hit_index, out_hit_index);
        compare_field("hit_kept", want.hit_kept, out_hit_kept);
        compare_field("hit_priority", want.hit_priority, out_hit_priority);
        compare_field("hit_matched", want.hit_matched, out_hit_matched);
        compare_field("event_done", want.event_done, out_event_done);
        compare_field("event_matched", want.event_matched, out_event_matched);
        compare_field("matched_count", want.matched_count, out_matched_count);
        compare_field("low_pair_count", want.low_pair_count, out_low_pair_count);
        compare_field("high_pair_count", want.high_pair_count, out_high_pair_count);
        compare_field("best_priority", want.best_priority, out_best_priority);
        compare_field("best_time_diff", want.best_time_diff, out_best_time_diff);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!src_busy) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drop valid and wait until every expected word has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_reg(input logic [vhep_pkg::CFG_IDX_W-1:0] idx,
                          input logic [vhep_pkg::CFG_DATA_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      vhep_pkg::CFG_REF_TIME:     reg_ref = val;
      vhep_pkg::CFG_STATION_MASK: reg_mask = val[vhep_pkg::MASK_W-1:0];
      vhep_pkg::CFG_NOISY_A, vhep_pkg::CFG_NOISY_B, vhep_pkg::CFG_NOISY_C,
      vhep_pkg::CFG_NOISY_D, vhep_pkg::CFG_NOISY_E: begin
        reg_noisy[idx - vhep_pkg::CFG_NOISY_A] = val[vhep_pkg::CHAN_W-1:0];
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // send one word and queue what it should produce
  task automatic push_hit(input hit_t h, input int gap, input bit typed,
                          input vhep_pkg::result_t want);
    vhep_pkg::result_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_station <= h.station;
    in_channel_id <= h.channel;
    in_hit_time <= h.hit_time;
    in_edge_mask <= h.edges;
    in_last_hit <= h.last;
    do @(posedge clk); while (!in_ready);
    predicted = tally_hit(h);
    pending_words.push_back(typed ? want : predicted);
  endtask

  function automatic plan_row_t hit_row(logic [3:0] st, logic [16:0] ch, logic [31:0] t,
                                        logic [3:0] e, bit last);
    plan_row_t r;
    r.kind = ROW_HIT;
    r.hit.station = st;
    r.hit.channel = ch;
    r.hit.hit_time = t;
    r.hit.edges = e;
    r.hit.last = last;
    r.reg_idx = vhep_pkg::CFG_REF_TIME;
    r.reg_val = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [vhep_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    plan_row_t r;
    r = hit_row(4'd0, '0, '0, 4'd0, 1'b0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = v;
    return r;
  endfunction

  function automatic hit_t random_hit(bit last);
    hit_t h;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) h.station = 4'($urandom_range(1, vhep_pkg::STATIONS));
    else if (sel == 8) h.station = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
    else h.station = 4'($urandom_range(0, 15));
    sel = $urandom_range(0, 19);
    if (sel < 5) h.channel = reg_noisy[$urandom_range(0, vhep_pkg::NOISY_NUM - 1)];
    else if (sel < 7) h.channel = ($urandom_range(0, 1) == 0) ? vhep_pkg::EMPTY_SLOT : '0;
    else h.channel = 17'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 4) h.hit_time = reg_ref + 32'($urandom_range(0, 4095)) - 32'd2048;
    else if (sel < 6) h.hit_time = reg_ref + 32'($urandom_range(0, 1 << 20)) - 32'd524288;
    else if (sel < 9) h.hit_time = $urandom;
    else h.hit_time = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    h.edges = 4'($urandom_range(0, 15));
    h.last = last;
    return h;
  endfunction

  // new register set for a phase, garbage in the unused upper bits
  task automatic randomize_regs();
    logic [31:0] r;
    int sel;
    sel = $urandom_range(0, 9);
    r = $urandom;
    if (sel < 3) r = '0;
    else if (sel == 3) r = 32'h7FFF_FFFF;
    else if (sel == 4) r = 32'h8000_0000;
    load_reg(vhep_pkg::CFG_REF_TIME, r);
    sel = $urandom_range(0, 9);
    r = $urandom;
    if (sel < 4) r[vhep_pkg::MASK_W-1:0] = '0;
    else if (sel == 4) r[vhep_pkg::MASK_W-1:0] = '1;
    load_reg(vhep_pkg::CFG_STATION_MASK, r);
    for (int k = 0; k < vhep_pkg::NOISY_NUM; k++) begin
      sel = $urandom_range(0, 9);
      r = $urandom;
      if (sel < 3) r[vhep_pkg::CHAN_W-1:0] = vhep_pkg::EMPTY_SLOT;
      else if (sel == 3) r[vhep_pkg::CHAN_W-1:0] = '0;
      load_reg((vhep_pkg::CFG_IDX_W)'(vhep_pkg::CFG_NOISY_A + k), r);
    end
  endtask

  initial begin
    plan_row_t row;
    hit_t h;
    int rand_hits;
    int n_events;
    int len;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= vhep_pkg::CFG_REF_TIME;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_station <= '0;
    in_channel_id <= '0;
    in_hit_time <= '0;
    in_edge_mask <= '0;
    in_last_hit <= 1'b0;
    out_ready <= 1'b0;

    // register defaults after reset
    reg_ref = '0;
    reg_mask = '0;
    reg_noisy[0] = vhep_pkg::NOISY_A_RST;
    reg_noisy[1] = vhep_pkg::NOISY_B_RST;
    reg_noisy[2] = vhep_pkg::NOISY_C_RST;
    reg_noisy[3] = vhep_pkg::NOISY_D_RST;
    reg_noisy[4] = vhep_pkg::NOISY_E_RST;
    clear_event();

    // directed table
    row = hit_row(4'd1, 17'd0, 32'd0, 4'hF, 1'b1);
    row.typed = 1'b1;
    row.want.hit_index = '0;
    row.want.hit_kept = 1'b1;
    row.want.hit_priority = 4'd15;
    row.want.hit_matched = 1'b1;
    row.want.event_done = 1'b1;
    row.want.event_matched = 1'b1;
    row.want.matched_count = 8'd1;
    row.want.low_pair_count = 11'd1;
    row.want.high_pair_count = 11'd1;
    row.want.best_priority = 4'd15;
    row.want.best_time_diff = '0;
    plan.push_back(row);
    // station zero, nothing kept: totals stay empty
    row = hit_row(4'd0, 17'd5, 32'd256, 4'h3, 1'b1);
    row.typed = 1'b1;
    row.want = '0;
    row.want.hit_priority = 4'd10;
    row.want.event_done = 1'b1;
    row.want.best_time_diff = vhep_pkg::DIFF_NONE;
    plan.push_back(row);
    // every edge mask, stations 0..15, noisy and all-ones channels, time extremes
    for (int e = 0; e < 16; e++) begin
      row = hit_row(4'(e),
                    (e == 2) ? 17'd84083 : (e == 5) ? vhep_pkg::EMPTY_SLOT :
                    (e == 7) ? 17'd0 : 17'(e * 1000 + 7),
                    (e == 3) ? 32'h7FFF_FFFF : (e == 6) ? 32'h8000_0000 : 32'((e - 8) * 300),
                    4'(e), e == 15);
      plan.push_back(row);
    end
    // equal magnitudes: the earlier difference stays
    plan.push_back(hit_row(4'd3, 17'd11, 32'd512, 4'h9, 1'b0));
    plan.push_back(hit_row(4'd4, 17'd12, -32'sd512, 4'h9, 1'b1));
    // negative overflow, masked station, mask bits above 11, emptied noisy slot
    plan.push_back(reg_row(vhep_pkg::CFG_REF_TIME, 32'h7FFF_FFFF));
    plan.push_back(reg_row(vhep_pkg::CFG_STATION_MASK, 32'hFFFF_F001));
    plan.push_back(reg_row(vhep_pkg::CFG_NOISY_A, 32'hFFFF_FFFF));
    plan.push_back(hit_row(4'd1, 17'd1, 32'd0, 4'hF, 1'b0));
    plan.push_back(hit_row(4'd2, 17'd84083, 32'h8000_0000, 4'hF, 1'b0));
    plan.push_back(hit_row(4'd12, vhep_pkg::EMPTY_SLOT, 32'h7FFF_FFFF, 4'h7, 1'b1));
    // positive overflow at the lowest selecting priority
    plan.push_back(reg_row(vhep_pkg::CFG_REF_TIME, 32'h8000_0000));
    plan.push_back(hit_row(4'd5, 17'd2, 32'h7FFF_FFFF, 4'hE, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_busy = ($urandom_range(0, 1) != 0);
    sink_busy = ($urandom_range(0, 1) != 0);
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) load_reg(plan[i].reg_idx, plan[i].reg_val);
      else push_hit(plan[i].hit, pick_gap(), plan[i].typed, plan[i].want);
    end

    // one long event: index wrap, match cap and pair saturation
    load_reg(vhep_pkg::CFG_REF_TIME, $urandom_range(0, 1 << 16));
    load_reg(vhep_pkg::CFG_STATION_MASK, 32'hFFFF_F000);
    for (int k = 0; k < vhep_pkg::NOISY_NUM; k++)
      load_reg((vhep_pkg::CFG_IDX_W)'(vhep_pkg::CFG_NOISY_A + k), 32'hFFFF_FFFF);
    src_busy = 1'b1;
    sink_busy = 1'b1;
    for (int k = 0; k < LONG_EVENT; k++) begin
      h = random_hit(k == LONG_EVENT - 1);
      h.station = 4'($urandom_range(1, vhep_pkg::STATIONS));
      if (k < LONG_FULL || $urandom_range(0, 3) != 0) h.edges = 4'hF;
      push_hit(h, ($urandom_range(0, 3) == 0) ? pick_gap() : 0, 1'b0, '0);
    end

    // random phases, each with its own register set
    rand_hits = 0;
    while (rand_hits < RANDOM_HITS) begin
      randomize_regs();
      src_busy = ($urandom_range(0, 2) != 0);
      sink_busy = ($urandom_range(0, 2) != 0);
      n_events = $urandom_range(2, 8);
      repeat (n_events) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) push_hit(random_hit(k == len - 1), pick_gap(), 1'b0, '0);
        rand_hits += len;
        if ($urandom_range(0, 7) == 0) settle();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
